FILE: rtl/i2cjs_pkg.sv
// Shared types, sizes and codes for the I2C master job sequencer.
// Used by the channel interfaces, the job and tx memories and the top level.
// No dependencies.
package i2cjs_pkg;

  localparam int unsigned QUEUE_DEPTH  = 32;
  localparam int unsigned BUFFER_BYTES = 32;

  localparam int unsigned QPW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILLW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CNTW  = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES + 1) : 1;
  localparam int unsigned TXAW  = $clog2(QUEUE_DEPTH * BUFFER_BYTES);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_EVENT = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_START     = 3'd1,
    ACT_RESTART   = 3'd2,
    ACT_TRANSMIT  = 3'd3,
    ACT_RX_ENABLE = 3'd4,
    ACT_ACK       = 3'd5,
    ACT_NACK      = 3'd6,
    ACT_STOP      = 3'd7
  } action_e;

  typedef enum logic [7:0] {
    PH_ADDRESSING   = 8'b0000_0001,
    PH_ACK_HIGH     = 8'b0000_0010,
    PH_ACK_LOW      = 8'b0000_0100,
    PH_RESTART      = 8'b0000_1000,
    PH_READ_REQUEST = 8'b0001_0000,
    PH_READING      = 8'b0010_0000,
    PH_WRITING      = 8'b0100_0000,
    PH_END          = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  device_address;
    logic        wide_address;
    logic [15:0] register_address;
    logic [5:0]  byte_count;
    logic [7:0]  data_byte;
    logic [4:0]  byte_index;
    logic        start_seen;
    logic        ack_received;
    logic        receive_full;
  } in_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] tx_value;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [4:0] rx_position;
    logic       read_done;
    logic       job_dropped;
  } out_t;

  typedef struct packed {
    logic [6:0]      device;
    logic            wide;
    logic [15:0]     register_address;
    logic [CNTW-1:0] count;
    logic            is_read;
  } job_t;

  typedef struct packed {
    logic           en;
    logic [QPW-1:0] addr;
  } job_rd_t;

  typedef struct packed {
    logic           en;
    logic [QPW-1:0] addr;
    job_t           data;
  } job_wr_t;

  typedef struct packed {
    logic            en;
    logic [TXAW-1:0] addr;
  } tx_rd_t;

  typedef struct packed {
    logic            en;
    logic [TXAW-1:0] addr;
    logic [7:0]      data;
  } tx_wr_t;

  function automatic logic [TXAW-1:0] tx_addr(input logic [QPW-1:0] slot,
                                              input logic [TXAW-1:0] pos);
    tx_addr = TXAW'(slot) * TXAW'(BUFFER_BYTES) + pos;
  endfunction

  function automatic logic [QPW-1:0] wrap_next(input logic [QPW-1:0] p);
    wrap_next = (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + QPW'(1);
  endfunction

endpackage

FILE: rtl/i2cjs_if.sv
// Valid/ready channel interfaces for the job sequencer request and result words.
// Depends on i2cjs_pkg for the payload structs.
interface i2cjs_in_if;
  import i2cjs_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2cjs_out_if;
  import i2cjs_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/i2c_master_job_sequencer.sv
// Top level of the I2C master job sequencer: queue pointers, bus phase and output register.
// Depends on i2cjs_pkg, i2cjs_if, i2cjs_job_ram and i2cjs_tx_ram.
//
//   channel  dir  handshake      word
//   in_i     in   valid/ready    in_t  (operation, job fields, bus event flags)
//   out_o    out  valid/ready    out_t (bus command, tx byte, rx byte, flags)
//
// Each word is handled in turn: the job and tx memories are read at the
// queue tail, then the sequencer computes, writes back and loads the output
// register. The next word is taken while a result waits; the compute step
// holds until the output register is free. Reset clears pointers, fill and
// phase; both memories are left unset.
module i2c_master_job_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cjs_in_if.sink    in_i,
  i2cjs_out_if.source out_o
);
  import i2cjs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e           state_q, state_d;
  in_t              item_q;
  phase_e           phase_q, phase_d;
  logic [CNTW-1:0]  bp_q, bp_d;
  logic [QPW-1:0]   head_q, head_d;
  logic [QPW-1:0]   tail_q, tail_d;
  logic [FILLW-1:0] fill_q, fill_d;
  logic             out_valid_q;
  out_t             out_q, res;

  job_rd_t    job_rd;
  job_wr_t    job_wr;
  job_t       job;
  tx_rd_t     tx_rd;
  tx_wr_t     tx_wr;
  logic [7:0] tx_byte;

  logic          in_accept;
  logic          exec_go;
  logic [CNTW:0] bp_inc;
  logic [5:0]    cnt_raw;
  logic [CNTW:0] cnt_sat;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;
  assign exec_go    = (state_q == ST_EXEC) && (!out_valid_q || out_o.ready);

  assign job_rd.en   = in_accept;
  assign job_rd.addr = tail_q;
  assign tx_rd.en    = in_accept;
  assign tx_rd.addr  = tx_addr(tail_q, TXAW'(bp_q));

  i2cjs_job_ram u_job_ram (
    .clk_i     (clk_i),
    .rd_i      (job_rd),
    .rd_data_o (job),
    .wr_i      (job_wr)
  );

  i2cjs_tx_ram u_tx_ram (
    .clk_i     (clk_i),
    .rd_i      (tx_rd),
    .rd_data_o (tx_byte),
    .wr_i      (tx_wr)
  );

  assign bp_inc = {1'b0, bp_q} + (CNTW + 1)'(1);

  always_comb begin
    cnt_raw = (item_q.byte_count == 6'd0) ? 6'd1 : item_q.byte_count;
    cnt_sat = (32'(cnt_raw) > BUFFER_BYTES) ? (CNTW + 1)'(BUFFER_BYTES)
                                            : (CNTW + 1)'(cnt_raw);
  end

  always_comb begin
    res     = '0;
    phase_d = phase_q;
    bp_d    = bp_q;
    head_d  = head_q;
    tail_d  = tail_q;
    fill_d  = fill_q;
    job_wr  = '0;
    tx_wr   = '0;
    state_d = state_q;

    case (op_e'(item_q.operation))
      OP_LOAD: begin
        if (fill_q < FILLW'(QUEUE_DEPTH) && 32'(item_q.byte_index) < BUFFER_BYTES) begin
          tx_wr.en   = exec_go;
          tx_wr.addr = tx_addr(head_q, TXAW'(item_q.byte_index));
          tx_wr.data = item_q.data_byte;
        end
      end
      OP_WRITE, OP_READ: begin
        if (fill_q >= FILLW'(QUEUE_DEPTH)) begin
          res.job_dropped = 1'b1;
        end else begin
          job_wr.en                    = exec_go;
          job_wr.addr                  = head_q;
          job_wr.data.device           = item_q.device_address;
          job_wr.data.wide             = item_q.wide_address;
          job_wr.data.register_address = item_q.register_address;
          job_wr.data.count            = cnt_sat[CNTW-1:0];
          job_wr.data.is_read          = (op_e'(item_q.operation) == OP_READ);
          head_d = wrap_next(head_q);
          if (fill_q == '0) begin
            res.bus_action = ACT_START;
            phase_d        = PH_ADDRESSING;
          end
          fill_d = fill_q + FILLW'(1);
        end
      end
      OP_EVENT: begin
        case (phase_q)
          PH_ADDRESSING: begin
            if (fill_q != '0) begin
              if (item_q.start_seen) begin
                bp_d           = '0;
                res.bus_action = ACT_TRANSMIT;
                res.tx_value   = {job.device, 1'b0};
                phase_d        = PH_ACK_HIGH;
              end else begin
                res.bus_action = ACT_START;
              end
            end
          end
          PH_ACK_HIGH: begin
            if (item_q.ack_received) begin
              res.bus_action = ACT_TRANSMIT;
              if (job.wide) begin
                res.tx_value = job.register_address[15:8];
                phase_d      = PH_ACK_LOW;
              end else begin
                res.tx_value = job.register_address[7:0];
                phase_d      = job.is_read ? PH_RESTART : PH_WRITING;
              end
            end
          end
          PH_ACK_LOW: begin
            if (item_q.ack_received) begin
              res.bus_action = ACT_TRANSMIT;
              res.tx_value   = job.register_address[7:0];
              phase_d        = job.is_read ? PH_RESTART : PH_WRITING;
            end
          end
          PH_RESTART: begin
            if (item_q.ack_received) begin
              res.bus_action = ACT_RESTART;
              phase_d        = PH_READ_REQUEST;
            end
          end
          PH_READ_REQUEST: begin
            if (item_q.start_seen) begin
              res.bus_action = ACT_TRANSMIT;
              res.tx_value   = {job.device, 1'b1};
              phase_d        = PH_READING;
            end
          end
          PH_READING: begin
            if (item_q.receive_full) begin
              res.rx_valid    = 1'b1;
              res.rx_byte     = item_q.data_byte;
              res.rx_position = 5'(bp_q);
              if (bp_inc >= {1'b0, job.count}) begin
                bp_d           = '0;
                res.bus_action = ACT_NACK;
                phase_d        = PH_END;
              end else begin
                bp_d           = bp_inc[CNTW-1:0];
                res.bus_action = ACT_ACK;
              end
            end else if (item_q.ack_received) begin
              res.bus_action = ACT_RX_ENABLE;
            end
          end
          PH_WRITING: begin
            if (item_q.ack_received) begin
              res.bus_action = ACT_TRANSMIT;
              if (32'(bp_q) < BUFFER_BYTES) begin
                res.tx_value = tx_byte;
              end
              bp_d = bp_inc[CNTW-1:0];
              if (bp_inc >= {1'b0, job.count}) begin
                phase_d = PH_END;
              end
            end
          end
          PH_END: begin
            res.bus_action = ACT_STOP;
            res.read_done  = job.is_read;
            bp_d           = '0;
            if (fill_q != '0) begin
              tail_d = wrap_next(tail_q);
              fill_d = fill_q - FILLW'(1);
            end
            phase_d = PH_ADDRESSING;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    if (in_accept) begin
      state_d = ST_EXEC;
    end else if (exec_go) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_ADDRESSING;
      bp_q        <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_go) begin
        phase_q     <= phase_d;
        bp_q        <= bp_d;
        head_q      <= head_d;
        tail_q      <= tail_d;
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_i.data;
    end
    if (exec_go) begin
      out_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILLW'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (head_q == tail_q))
    else $error("empty queue with head and tail apart");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_EXEC))
    else $error("accepted word not executed");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("result without execution");

  a_done_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.read_done) |-> (out_q.bus_action == ACT_STOP))
    else $error("read done without stop");
`endif

endmodule

FILE: rtl/i2cjs_job_ram.sv
// Job descriptor memory, one entry per queue slot, registered read.
// Depends on i2cjs_pkg.
module i2cjs_job_ram (
  input  logic               clk_i,
  input  i2cjs_pkg::job_rd_t rd_i,
  output i2cjs_pkg::job_t    rd_data_o,
  input  i2cjs_pkg::job_wr_t wr_i
);
  import i2cjs_pkg::*;

  job_t mem [QUEUE_DEPTH];
  job_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/i2cjs_tx_ram.sv
// Transmit byte memory, one buffer per queue slot, registered read.
// Depends on i2cjs_pkg.
module i2cjs_tx_ram (
  input  logic              clk_i,
  input  i2cjs_pkg::tx_rd_t rd_i,
  output logic [7:0]        rd_data_o,
  input  i2cjs_pkg::tx_wr_t wr_i
);
  import i2cjs_pkg::*;

  logic [7:0] mem [QUEUE_DEPTH * BUFFER_BYTES];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
